// ===== design/kcl_pkg.sv =====
package kcl_pkg;

  // Digits in one code
  localparam int CODE_LENGTH = 4;
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_LENGTH - 1);

  // Configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [2:0] REG_BLINK        = 3'd1;
  localparam logic [2:0] REG_MAX_TRIES    = 3'd2;
  localparam logic [2:0] REG_BEEP_STORED  = 3'd3;
  localparam logic [2:0] REG_BEEP_CORRECT = 3'd4;
  localparam logic [2:0] REG_BEEP_WRONG   = 3'd5;
  localparam logic [2:0] REG_BEEP_LOCKOUT = 3'd6;

  // Phase codes
  localparam logic [1:0] PH_CAPTURE = 2'd0;
  localparam logic [1:0] PH_IDLE    = 2'd1;
  localparam logic [1:0] PH_ENTER   = 2'd2;

  // Event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_STORED   = 3'd1;
  localparam logic [2:0] EV_UNLOCKED = 3'd2;
  localparam logic [2:0] EV_LOCKED   = 3'd3;
  localparam logic [2:0] EV_WRONG    = 3'd4;
  localparam logic [2:0] EV_TOO_MANY = 3'd5;

  typedef struct packed {
    logic [3:0] button_levels;
    logic       enter_n;
  } kcl_in_t;

  typedef struct packed {
    logic       locked;
    logic       status_led;
    logic       buzzer_on;
    logic [1:0] phase;
    logic [2:0] digit_taken;
    logic [2:0] event_res;
    logic [2:0] tries_left;
  } kcl_out_t;

  typedef struct packed {
    logic       we;
    logic [2:0] index;
    logic [7:0] wdata;
  } kcl_cfg_wr_t;

endpackage

// ===== design/kcl_core.sv =====
module kcl_core import kcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  kcl_in_t     item,
  input  kcl_cfg_wr_t cfg,
  output kcl_out_t    result
);

  // Configuration registers
  logic [7:0] debounce_r, blink_ticks_r, beep_stored_r, beep_correct_r;
  logic [7:0] beep_wrong_r, beep_lockout_r;
  logic [2:0] max_tries_r;

  // Lock state
  logic [1:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic             locked_r, locked_nxt;
  logic [2:0]       fail_r, fail_nxt;
  logic [7:0]       blink_r, blink_nxt;
  logic             led_r, led_nxt;
  logic [7:0]       beep_r, beep_nxt;
  logic [1:0]       stored_r [CODE_LENGTH];
  logic [1:0]       attempt_r [CODE_LENGTH];

  // Step logic helpers
  logic [2:0] taken;
  logic [1:0] digit;
  logic [7:0] hold_inc, blink_inc, beep_mid;
  logic [2:0] fail_inc;
  logic       wr_digit, done, match;
  logic [2:0] event_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= 8'd6;
      blink_ticks_r  <= 8'd30;
      max_tries_r    <= 3'd3;
      beep_stored_r  <= 8'd5;
      beep_correct_r <= 8'd15;
      beep_wrong_r   <= 8'd25;
      beep_lockout_r <= 8'd30;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_DEBOUNCE:     debounce_r     <= cfg.wdata;
        REG_BLINK:        blink_ticks_r  <= cfg.wdata;
        REG_MAX_TRIES:    max_tries_r    <= cfg.wdata[2:0];
        REG_BEEP_STORED:  beep_stored_r  <= cfg.wdata;
        REG_BEEP_CORRECT: beep_correct_r <= cfg.wdata;
        REG_BEEP_WRONG:   beep_wrong_r   <= cfg.wdata;
        REG_BEEP_LOCKOUT: beep_lockout_r <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // One tick of the lock
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    hold_nxt   = hold_r;
    locked_nxt = locked_r;
    fail_nxt   = fail_r;
    beep_mid   = beep_r;
    taken      = 3'd0;
    event_code = EV_NONE;
    wr_digit   = 1'b0;
    done       = 1'b0;
    match      = 1'b1;
    hold_inc   = (hold_r == 8'hFF) ? hold_r : hold_r + 8'd1;
    fail_inc   = (fail_r == 3'd7) ? fail_r : fail_r + 3'd1;

    // priority encode, button 1 first
    if (item.button_levels[0])      digit = 2'd0;
    else if (item.button_levels[1]) digit = 2'd1;
    else if (item.button_levels[2]) digit = 2'd2;
    else                            digit = 2'd3;

    // stored against attempt, last attempt digit is the one arriving now
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (IDX_W'(i) == LAST_IDX) begin
        if (stored_r[i] != digit) match = 1'b0;
      end else if (stored_r[i] != attempt_r[i]) begin
        match = 1'b0;
      end
    end

    case (phase_r)
      PH_IDLE: begin
        if (!item.enter_n) begin
          phase_nxt = PH_ENTER;
          idx_nxt   = '0;
          hold_nxt  = 8'd0;
        end
      end
      PH_CAPTURE, PH_ENTER: begin
        // debounced sampler
        if (item.button_levels == 4'd0) begin
          hold_nxt = 8'd0;
        end else if (hold_inc >= debounce_r) begin
          hold_nxt = 8'd0;
          taken    = {1'b0, digit} + 3'd1;
          wr_digit = 1'b1;
        end else begin
          hold_nxt = hold_inc;
        end
        if (wr_digit) begin
          if (idx_r == LAST_IDX) begin
            done = 1'b1;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        if (done) begin
          idx_nxt   = '0;
          hold_nxt  = 8'd0;
          phase_nxt = PH_IDLE;
          if (phase_r == PH_CAPTURE) begin
            event_code = EV_STORED;
            beep_mid   = beep_stored_r;
          end else if (match) begin
            event_code = locked_r ? EV_UNLOCKED : EV_LOCKED;
            locked_nxt = ~locked_r;
            fail_nxt   = 3'd0;
            beep_mid   = beep_correct_r;
          end else begin
            fail_nxt = fail_inc;
            if (fail_inc >= max_tries_r) begin
              event_code = EV_TOO_MANY;
              beep_mid   = beep_lockout_r;
            end else begin
              event_code = EV_WRONG;
              beep_mid   = beep_wrong_r;
            end
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    // blink timer runs in every phase
    blink_inc = (blink_r == 8'hFF) ? blink_r : blink_r + 8'd1;
    blink_nxt = blink_inc;
    led_nxt   = led_r;
    if (locked_nxt && (blink_inc >= blink_ticks_r)) begin
      led_nxt   = ~led_r;
      blink_nxt = 8'd0;
    end

    // beep countdown
    beep_nxt = (beep_mid != 8'd0) ? beep_mid - 8'd1 : beep_mid;

    result.locked      = locked_nxt;
    result.status_led  = led_nxt;
    result.buzzer_on   = (beep_mid != 8'd0);
    result.phase       = phase_nxt;
    result.digit_taken = taken;
    result.event_res   = event_code;
    result.tries_left  = (max_tries_r > fail_nxt) ? max_tries_r - fail_nxt : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CAPTURE;
      idx_r    <= '0;
      hold_r   <= 8'd0;
      locked_r <= 1'b1;
      fail_r   <= 3'd0;
      blink_r  <= 8'd0;
      led_r    <= 1'b1;
      beep_r   <= 8'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      hold_r   <= hold_nxt;
      locked_r <= locked_nxt;
      fail_r   <= fail_nxt;
      blink_r  <= blink_nxt;
      led_r    <= led_nxt;
      beep_r   <= beep_nxt;
    end
  end

  // Code stores, no reset: every digit is written before it is read
  always_ff @(posedge clk) begin
    if (step && wr_digit) begin
      if (phase_r == PH_CAPTURE) begin
        stored_r[idx_r] <= digit;
      end else begin
        attempt_r[idx_r] <= digit;
      end
    end
  end

  // A correct attempt clears the failure count
  a_match_clears_fails: assert property (@(posedge clk) disable iff (!rst_n)
    step && (result.event_res == EV_UNLOCKED || result.event_res == EV_LOCKED)
    |=> fail_r == 3'd0)
    else $error("failure count not cleared after correct attempt");

  // Unlock event leaves the lock open
  a_unlock_state: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.event_res == EV_UNLOCKED |-> !result.locked && locked_r)
    else $error("unlock event with inconsistent lock state");

  // Every event returns to idle
  a_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.event_res != EV_NONE |-> result.phase == PH_IDLE)
    else $error("event raised outside completion of a code");

  // Digits are only taken while capturing or entering
  a_digit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.digit_taken != 3'd0 |-> phase_r == PH_CAPTURE || phase_r == PH_ENTER)
    else $error("digit taken in idle phase");

endmodule

// ===== design/keypad_combination_lock_top.sv =====
// An accepted input beat waits in the input register; the result register loads it once it is
// free or draining. Throughput: one beat per cycle unless out_ready stalls the result register;
// the lock state update is a single pass of logic per tick.
// Ready on the input side follows the result register's free slot combinationally.
// Reset (rst_n low, synchronous): code capture phase, locked, LED on, counters and buzzer cleared,
// configuration registers at their defaults. Code digit stores are not reset.
module keypad_combination_lock_top import kcl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  kcl_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output kcl_out_t   out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic        in_valid_r;
  kcl_in_t     in_r;
  logic        out_valid_r;
  kcl_out_t    out_r;
  logic        step;
  kcl_out_t    result;
  kcl_cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  // Held beat moves on when the result register is free or draining
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  kcl_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_r),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
